// File: src/tcw_pkg.sv
// Shared constants for the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

   localparam int ACTION_W = 2;
   localparam int CODE_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int RROW_W   = 5;
   localparam int RCOL_W   = 7;
   localparam int CELL_W   = CODE_W + ATTR_W;

   localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [CODE_W-1:0] BLANK_CODE   = 8'h20;

endpackage

// File: src/tcw_if.sv
// Request and response channel interfaces of the text console writer.
`timescale 1ns / 1ps
interface tcw_req_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::ACTION_W-1:0]  action;
   logic [tcw_pkg::CODE_W-1:0]    char_code;
   logic [tcw_pkg::ATTR_W-1:0]    color;
   logic [tcw_pkg::RROW_W-1:0]    read_row;
   logic [tcw_pkg::RCOL_W-1:0]    read_col;

   modport source (output valid, action, char_code, color, read_row, read_col, input ready);
   modport sink (input valid, action, char_code, color, read_row, read_col, output ready);
endinterface

interface tcw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tcw_pkg::RCOL_W-1:0]  cursor_col;
   logic [tcw_pkg::RROW_W-1:0]  cursor_row;
   logic                        scrolled;
   logic [tcw_pkg::CELL_W-1:0]  cell_data;

   modport source (output valid, cursor_col, cursor_row, scrolled, cell_data, input ready);
   modport sink (input valid, cursor_col, cursor_row, scrolled, cell_data, output ready);
endinterface

// File: src/text_console_writer_core.sv
// Text console writer: cursor, row ring and screen cell store.
`timescale 1ns / 1ps
// The screen lives in one RAM addressed as {physical row, column}; a top-row
// pointer turns the store into a ring, so a scroll moves no cells and only
// blanks the freed row, one cell per cycle. A put goes from idle to done; a
// put that scrolls and a clear first sweep the freed row or the whole store
// through the single RAM write port, and a read waits in a read state for the
// registered RAM data. After reset the block zeroes the store in a sweep pass
// and accepts no item until it ends. One item is worked at a time; the
// response register lets the next item enter while a result waits.
module text_console_writer_core #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic       clock,
   input  logic       reset,
   tcw_req_if.sink    req_ch,
   tcw_rsp_if.source  rsp_ch
);

   localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int DEPTH = ROWS * (2 ** COL_W);
   localparam int AW    = ROW_W + COL_W;

   localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [COL_W:0]   COLS_EXT = (COL_W + 1)'(COLUMNS);
   localparam logic [ROW_W:0]   ROWS_EXT = (ROW_W + 1)'(ROWS);

   typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_READ, ST_DONE} state_type;

   state_type                   state_ff, state_in;
   logic [COL_W-1:0]            cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]            cur_row_ff, cur_row_in;
   logic [ROW_W-1:0]            top_ff, top_in;
   logic [ROW_W-1:0]            sw_row_ff, sw_row_in;
   logic [COL_W-1:0]            sw_col_ff, sw_col_in;
   logic                        sw_all_ff, sw_all_in;
   logic                        sw_rsp_ff, sw_rsp_in;
   logic [tcw_pkg::CELL_W-1:0]  fill_ff, fill_in;
   logic                        pend_scroll_ff, pend_scroll_in;
   logic [tcw_pkg::CELL_W-1:0]  pend_cell_ff, pend_cell_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::RCOL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [tcw_pkg::RROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic                        rsp_scroll_ff, rsp_scroll_in;
   logic [tcw_pkg::CELL_W-1:0]  rsp_cell_ff, rsp_cell_in;

   logic                        ram_we;
   logic [AW-1:0]               ram_waddr;
   logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
   logic                        ram_re;
   logic [AW-1:0]               ram_raddr;
   logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

   logic [ROW_W-1:0]            rd_row;
   logic [COL_W-1:0]            rd_col;
   logic                        rd_in_range;
   logic [ROW_W-1:0]            log_row;
   logic [ROW_W:0]              phys_sum;
   logic [ROW_W-1:0]            phys_row;
   logic [ROW_W-1:0]            top_inc;
   logic                        is_newline;
   logic [COL_W:0]              col_inc;
   logic                        adv_row;
   logic                        do_scroll;
   logic [COL_W-1:0]            put_col;
   logic [ROW_W-1:0]            put_row;

   assign rd_row      = ROW_W'(req_ch.read_row);
   assign rd_col      = COL_W'(req_ch.read_col);
   assign rd_in_range = (7'(req_ch.read_row) < 7'(ROWS)) &&
                        (8'(req_ch.read_col) < 8'(COLUMNS));

   assign log_row  = (req_ch.action == tcw_pkg::ACT_READ) ? rd_row : cur_row_ff;
   assign phys_sum = {1'b0, top_ff} + {1'b0, log_row};
   assign phys_row = (phys_sum >= ROWS_EXT) ? ROW_W'(phys_sum - ROWS_EXT)
                                            : ROW_W'(phys_sum);
   assign top_inc  = (top_ff == ROW_LAST) ? '0 : top_ff + ROW_W'(1);

   assign is_newline = (req_ch.char_code == tcw_pkg::NEWLINE_CODE);
   assign col_inc    = {1'b0, cur_col_ff} + (COL_W + 1)'(1);
   assign adv_row    = is_newline || (col_inc == COLS_EXT);
   assign do_scroll  = adv_row && (cur_row_ff == ROW_LAST);
   assign put_col    = adv_row ? '0 : COL_W'(col_inc);
   assign put_row    = do_scroll ? ROW_LAST :
                       (adv_row ? cur_row_ff + ROW_W'(1) : cur_row_ff);

   always_comb begin
      state_in       = state_ff;
      cur_col_in     = cur_col_ff;
      cur_row_in     = cur_row_ff;
      top_in         = top_ff;
      sw_row_in      = sw_row_ff;
      sw_col_in      = sw_col_ff;
      sw_all_in      = sw_all_ff;
      sw_rsp_in      = sw_rsp_ff;
      fill_in        = fill_ff;
      pend_scroll_in = pend_scroll_ff;
      pend_cell_in   = pend_cell_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_col_in     = rsp_col_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_scroll_in  = rsp_scroll_ff;
      rsp_cell_in    = rsp_cell_ff;
      ram_we         = 1'b0;
      ram_waddr      = {phys_row, cur_col_ff};
      ram_wdata      = {req_ch.color, req_ch.char_code};
      ram_re         = 1'b0;
      ram_raddr      = {phys_row, rd_col};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               pend_scroll_in = 1'b0;
               pend_cell_in   = '0;
               state_in       = ST_DONE;
               unique case (req_ch.action)
                  tcw_pkg::ACT_PUT: begin
                     ram_we     = !is_newline;
                     cur_col_in = put_col;
                     cur_row_in = put_row;
                     if (do_scroll) begin
                        top_in         = top_inc;
                        sw_row_in      = top_ff;
                        sw_col_in      = '0;
                        sw_all_in      = 1'b0;
                        sw_rsp_in      = 1'b1;
                        fill_in        = {req_ch.color, tcw_pkg::BLANK_CODE};
                        pend_scroll_in = 1'b1;
                        state_in       = ST_SWEEP;
                     end
                  end
                  tcw_pkg::ACT_CLEAR: begin
                     cur_col_in = '0;
                     cur_row_in = '0;
                     top_in     = '0;
                     sw_row_in  = '0;
                     sw_col_in  = '0;
                     sw_all_in  = 1'b1;
                     sw_rsp_in  = 1'b1;
                     fill_in    = {req_ch.color, tcw_pkg::BLANK_CODE};
                     state_in   = ST_SWEEP;
                  end
                  tcw_pkg::ACT_READ: begin
                     if (rd_in_range) begin
                        ram_re   = 1'b1;
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            ram_we    = 1'b1;
            ram_waddr = {sw_row_ff, sw_col_ff};
            ram_wdata = fill_ff;
            if (sw_col_ff == COL_LAST) begin
               sw_col_in = '0;
               if (!sw_all_ff || sw_row_ff == ROW_LAST) begin
                  state_in = sw_rsp_ff ? ST_DONE : ST_IDLE;
               end else begin
                  sw_row_in = sw_row_ff + ROW_W'(1);
               end
            end else begin
               sw_col_in = sw_col_ff + COL_W'(1);
            end
         end
         ST_READ: begin
            pend_cell_in = ram_rdata;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_col_in    = tcw_pkg::RCOL_W'(cur_col_ff);
               rsp_row_in    = tcw_pkg::RROW_W'(cur_row_ff);
               rsp_scroll_in = pend_scroll_ff;
               rsp_cell_in   = pend_cell_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         top_ff       <= '0;
         sw_row_ff    <= '0;
         sw_col_ff    <= '0;
         sw_all_ff    <= 1'b1;
         sw_rsp_ff    <= 1'b0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         top_ff       <= top_in;
         sw_row_ff    <= sw_row_in;
         sw_col_ff    <= sw_col_in;
         sw_all_ff    <= sw_all_in;
         sw_rsp_ff    <= sw_rsp_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_scroll_ff <= pend_scroll_in;
      pend_cell_ff   <= pend_cell_in;
      rsp_col_ff     <= rsp_col_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_scroll_ff  <= rsp_scroll_in;
      rsp_cell_ff    <= rsp_cell_in;
   end

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (DEPTH)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.cursor_col = rsp_col_ff;
   assign rsp_ch.cursor_row = rsp_row_ff;
   assign rsp_ch.scrolled   = rsp_scroll_ff;
   assign rsp_ch.cell_data  = rsp_cell_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (cur_row_ff <= ROW_LAST) && (cur_col_ff <= COL_LAST) && (top_ff <= ROW_LAST))
      else $error("cursor or top row out of range");

   a_sweep_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> !req_ch.ready && ram_we)
      else $error("item accepted or write missing during sweep");

   a_read_follows_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> $past(ram_re))
      else $error("read state without a RAM read");

endmodule

// File: src/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
